// ----- rtl/spherical_shell_step_locator_unit_macros.svh -----
// Assertion macros used by the checker file of the shell step locator.
`ifndef SPHERICAL_SHELL_STEP_LOCATOR_UNIT_MACROS_SVH
`define SPHERICAL_SHELL_STEP_LOCATOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSSL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sssl check failed");

// Consequent checked in the cycle after the antecedent.
`define SSSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sssl check failed");

`endif

// ----- rtl/sssl_pkg.sv -----
// Package: shell radius tables, widths and shared types of the shell step locator.
package sssl_pkg;

    localparam int NUM_SHELLS   = 15;
    localparam int TABLE_SHELLS = 15;
    localparam int SHELLS_USED  = (NUM_SHELLS < TABLE_SHELLS) ? NUM_SHELLS : TABLE_SHELLS;
    localparam int ONE_METRE    = 16;
    localparam int SQRT_STAGES  = 32;
    localparam int NUM_LANES    = 4;
    localparam int LAYER_W      = 4;
    localparam int B_W          = 35;   // projected distance along the ray
    localparam int S_W          = 37;   // signed step before clamping
    localparam int REM_W        = 36;   // square root partial remainder
    localparam int RADIUS_W     = 30;
    localparam int STEP_W       = 32;

    localparam longint SHELL_RADIUS [TABLE_SHELLS+1] = '{
        64'd19544000,  64'd55680000,  64'd91216000,  64'd92336000,
        64'd95536000,  64'd98416000,  64'd101545600, 64'd101696000,
        64'd101888000, 64'd101936000, 64'd102000000, 64'd102096000,
        64'd102576000, 64'd103536000, 64'd674624000, 64'd1349248000
    };

    typedef logic [63:0] rsq_tab_t [TABLE_SHELLS+1];

    function automatic rsq_tab_t make_rsq();
        rsq_tab_t t;
        for (int i = 0; i < TABLE_SHELLS + 1; i++) begin
            t[i] = 64'(SHELL_RADIUS[i] * SHELL_RADIUS[i]);
        end
        return t;
    endfunction

    localparam rsq_tab_t SHELL_RSQ = make_rsq();
    localparam logic [63:0] GEO_SQ = 64'(longint'(674624000) * longint'(674624000));

    typedef enum logic [1:0] {
        LANE_OUTER  = 2'd0,
        LANE_LOWER1 = 2'd1,
        LANE_LOWER2 = 2'd2,
        LANE_RADIUS = 2'd3
    } lane_t;

    typedef struct packed {
        logic                      outside;
        logic [LAYER_W-1:0]        layer;
        logic signed [B_W-1:0]     b;
        logic                      hit1;
        logic                      hit2;
    } side_t;

    typedef struct packed {
        logic                 outside;
        logic [LAYER_W-1:0]   layer;
        logic [RADIUS_W-1:0]  radius;
        logic [STEP_W-1:0]    step_len;
    } res_t;

endpackage

// ----- rtl/sssl_sqrt_pipe.sv -----
// Four-lane pipelined integer square root, one result bit per stage, with sideband.
module sssl_sqrt_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  sssl_pkg::side_t     in_side,
    input  logic [63:0]         in_rad [sssl_pkg::NUM_LANES],
    output logic                out_valid,
    output sssl_pkg::side_t     out_side,
    output logic [31:0]         out_root [sssl_pkg::NUM_LANES]
);

    logic                           valid_reg [sssl_pkg::SQRT_STAGES];
    sssl_pkg::side_t                side_reg  [sssl_pkg::SQRT_STAGES];
    logic [sssl_pkg::REM_W-1:0]     rem_reg   [sssl_pkg::SQRT_STAGES][sssl_pkg::NUM_LANES];
    logic [31:0]                    root_reg  [sssl_pkg::SQRT_STAGES][sssl_pkg::NUM_LANES];
    logic [63:0]                    rad_reg   [sssl_pkg::SQRT_STAGES][sssl_pkg::NUM_LANES];

    for (genvar k = 0; k < sssl_pkg::SQRT_STAGES; k++) begin : g_stage
        logic                       valid_prev;
        sssl_pkg::side_t            side_prev;
        logic [sssl_pkg::REM_W-1:0] rem_prev  [sssl_pkg::NUM_LANES];
        logic [31:0]                root_prev [sssl_pkg::NUM_LANES];
        logic [63:0]                rad_prev  [sssl_pkg::NUM_LANES];
        logic [sssl_pkg::REM_W-1:0] rem_next  [sssl_pkg::NUM_LANES];
        logic [31:0]                root_next [sssl_pkg::NUM_LANES];
        logic [63:0]                rad_next  [sssl_pkg::NUM_LANES];

        if (k == 0) begin : g_first
            always_comb begin
                valid_prev = in_valid;
                side_prev  = in_side;
                for (int l = 0; l < sssl_pkg::NUM_LANES; l++) begin
                    rem_prev[l]  = '0;
                    root_prev[l] = '0;
                    rad_prev[l]  = in_rad[l];
                end
            end
        end else begin : g_rest
            always_comb begin
                valid_prev = valid_reg[k-1];
                side_prev  = side_reg[k-1];
                for (int l = 0; l < sssl_pkg::NUM_LANES; l++) begin
                    rem_prev[l]  = rem_reg[k-1][l];
                    root_prev[l] = root_reg[k-1][l];
                    rad_prev[l]  = rad_reg[k-1][l];
                end
            end
        end

        // bring down two radicand bits, try root*4+1
        always_comb begin
            logic [sssl_pkg::REM_W-1:0] cand;
            logic [sssl_pkg::REM_W-1:0] trial;
            logic                       ge;
            for (int l = 0; l < sssl_pkg::NUM_LANES; l++) begin
                cand  = {rem_prev[l][sssl_pkg::REM_W-3:0], rad_prev[l][63:62]};
                trial = sssl_pkg::REM_W'({root_prev[l], 2'b01});
                ge    = (cand >= trial);
                rem_next[l]  = ge ? (cand - trial) : cand;
                root_next[l] = {root_prev[l][30:0], ge};
                rad_next[l]  = {rad_prev[l][61:0], 2'b00};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= side_prev;
                for (int l = 0; l < sssl_pkg::NUM_LANES; l++) begin
                    rem_reg[k][l]  <= rem_next[l];
                    root_reg[k][l] <= root_next[l];
                    rad_reg[k][l]  <= rad_next[l];
                end
            end
        end
    end

    assign out_valid = valid_reg[sssl_pkg::SQRT_STAGES-1];
    assign out_side  = side_reg[sssl_pkg::SQRT_STAGES-1];
    assign out_root  = root_reg[sssl_pkg::SQRT_STAGES-1];

endmodule

// ----- rtl/spherical_shell_step_locator_unit.sv -----
// Top level: spherical shell lookup and step length, fully pipelined.
// Throughput: one transaction per cycle, except while s_ready is low because the output
// buffer is full; the depth is set by the 32-stage square root.
// A two-entry output buffer lets the pipeline keep taking input while a result waits.
// Reset (synchronous, aresetn low) clears every valid bit; data registers are not reset.
module spherical_shell_step_locator_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic signed [31:0]  s_dir_x,
    input  logic signed [31:0]  s_dir_y,
    input  logic signed [31:0]  s_dir_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_outside,
    output logic [3:0]          m_layer,
    output logic [29:0]         m_radius,
    output logic [31:0]         m_step_len
);

    logic adv;

    // stage 1: squares and direction products
    logic               v1_reg;
    logic signed [63:0] sqx_reg, sqy_reg, sqz_reg, dpx_reg, dpy_reg, dpz_reg;
    logic signed [63:0] sqx_next, sqy_next, sqz_next, dpx_next, dpy_next, dpz_next;

    assign sqx_next = s_pos_x * s_pos_x;
    assign sqy_next = s_pos_y * s_pos_y;
    assign sqz_next = s_pos_z * s_pos_z;
    assign dpx_next = s_pos_x * s_dir_x;
    assign dpy_next = s_pos_y * s_dir_y;
    assign dpz_next = s_pos_z * s_dir_z;

    // stage 2: r^2 and the dot product sum
    logic               v2_reg;
    logic [63:0]        r2_2_reg, r2_2_next;
    logic signed [63:0] acc_reg, acc_next;

    assign r2_2_next = 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);
    assign acc_next  = (dpx_reg >>> 2) + (dpy_reg >>> 2) + (dpz_reg >>> 2);

    // stage 3: shell search and b
    logic                           v3_reg;
    logic [63:0]                    r2_3_reg;
    logic signed [sssl_pkg::B_W-1:0] b3_reg, b3_next;
    logic [sssl_pkg::LAYER_W-1:0]   layer3_reg, layer3_next;
    logic                           out3_reg, out3_next;

    assign b3_next = sssl_pkg::B_W'(acc_reg >>> 28);

    always_comb begin
        logic found;
        found       = 1'b0;
        layer3_next = '0;
        for (int i = sssl_pkg::SHELLS_USED - 1; i >= 0; i--) begin
            if (r2_2_reg <= sssl_pkg::SHELL_RSQ[i]) begin
                found       = 1'b1;
                layer3_next = sssl_pkg::LAYER_W'(i);
            end
        end
        out3_next = (r2_2_reg > sssl_pkg::GEO_SQ) || !found;
    end

    // stage 4: b^2 and boundary radius squares
    logic                           v4_reg;
    logic [63:0]                    r2_4_reg, bb_reg, bb_next;
    logic [63:0]                    rsq_o_reg, rsq_1_reg, rsq_2_reg;
    logic [63:0]                    rsq_o_next, rsq_1_next, rsq_2_next;
    logic signed [sssl_pkg::B_W-1:0] b4_reg;
    logic [sssl_pkg::LAYER_W-1:0]   layer4_reg;
    logic                           out4_reg, use1_reg, use2_reg, use1_next, use2_next;

    assign bb_next    = 64'(b3_reg * b3_reg);
    assign rsq_o_next = sssl_pkg::SHELL_RSQ[sssl_pkg::LAYER_W'(layer3_reg + 1'b1)];
    assign rsq_1_next = sssl_pkg::SHELL_RSQ[(layer3_reg >= 4'd1) ?
                                             sssl_pkg::LAYER_W'(layer3_reg - 4'd1) : '0];
    assign rsq_2_next = sssl_pkg::SHELL_RSQ[(layer3_reg >= 4'd2) ?
                                             sssl_pkg::LAYER_W'(layer3_reg - 4'd2) : '0];
    // downward ray also looks at up to two boundaries below
    assign use1_next  = (layer3_reg >= 4'd1) && b3_reg[sssl_pkg::B_W-1];
    assign use2_next  = use1_next && (layer3_reg >= 4'd2);

    // stage 5: discriminants, then into the square root
    logic                   v5_reg;
    logic [63:0]            rad5_reg  [sssl_pkg::NUM_LANES];
    logic [63:0]            rad5_next [sssl_pkg::NUM_LANES];
    sssl_pkg::side_t        side5_reg, side5_next;

    always_comb begin
        logic [63:0] q_o, q_1, q_2;
        logic        p_o, p_1, p_2;
        q_o = bb_reg + rsq_o_reg - r2_4_reg;
        q_1 = bb_reg + rsq_1_reg - r2_4_reg;
        q_2 = bb_reg + rsq_2_reg - r2_4_reg;
        p_o = !q_o[63] && (q_o != 64'd0);
        p_1 = !q_1[63] && (q_1 != 64'd0);
        p_2 = !q_2[63] && (q_2 != 64'd0);
        rad5_next[sssl_pkg::LANE_OUTER]  = p_o ? q_o : 64'd0;
        rad5_next[sssl_pkg::LANE_LOWER1] = p_1 ? q_1 : 64'd0;
        rad5_next[sssl_pkg::LANE_LOWER2] = p_2 ? q_2 : 64'd0;
        rad5_next[sssl_pkg::LANE_RADIUS] = r2_4_reg;
        side5_next.outside = out4_reg;
        side5_next.layer   = layer4_reg;
        side5_next.b       = b4_reg;
        side5_next.hit1    = use1_reg && p_1;
        side5_next.hit2    = use2_reg && p_2;
    end

    logic                   sq_valid;
    sssl_pkg::side_t        sq_side;
    logic [31:0]            sq_root [sssl_pkg::NUM_LANES];

    sssl_sqrt_pipe u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v5_reg),
        .in_side   (side5_reg),
        .in_rad    (rad5_reg),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // stage 6: candidate steps
    logic                            v6_reg;
    logic signed [sssl_pkg::S_W-1:0] so_reg, s1_reg, s2_reg, so_next, s1_next, s2_next;
    logic [sssl_pkg::RADIUS_W-1:0]   rad6_reg;
    logic [sssl_pkg::LAYER_W-1:0]    layer6_reg;
    logic                            out6_reg, hit1_reg, hit2_reg;
    logic signed [sssl_pkg::S_W-1:0] b_ext;

    assign b_ext   = sssl_pkg::S_W'($signed(sq_side.b));
    assign so_next = $signed({5'b0, sq_root[sssl_pkg::LANE_OUTER]}) - b_ext
                     - sssl_pkg::S_W'(sssl_pkg::ONE_METRE);
    assign s1_next = $signed({5'b0, sq_root[sssl_pkg::LANE_LOWER1]}) - b_ext
                     - sssl_pkg::S_W'(sssl_pkg::ONE_METRE);
    assign s2_next = $signed({5'b0, sq_root[sssl_pkg::LANE_LOWER2]}) - b_ext
                     - sssl_pkg::S_W'(sssl_pkg::ONE_METRE);

    // final: nearest hit, clamp, saturate
    sssl_pkg::res_t res;

    always_comb begin
        logic signed [sssl_pkg::S_W-1:0] step;
        step = so_reg;
        if (hit1_reg && (s1_reg < step)) step = s1_reg;
        if (hit2_reg && (s2_reg < step)) step = s2_reg;
        if (step < sssl_pkg::S_W'(sssl_pkg::ONE_METRE)) begin
            step = sssl_pkg::S_W'(sssl_pkg::ONE_METRE);
        end else if (step > $signed({5'b0, 32'hFFFF_FFFF})) begin
            step = $signed({5'b0, 32'hFFFF_FFFF});
        end
        if (out6_reg) begin
            res = '0;
            res.outside = 1'b1;
        end else begin
            res.outside  = 1'b0;
            res.layer    = layer6_reg;
            res.radius   = rad6_reg;
            res.step_len = step[sssl_pkg::STEP_W-1:0];
        end
    end

    // two-entry output buffer
    logic           ov_reg, ov_next, kv_reg, kv_next;
    sssl_pkg::res_t od_reg, od_next, kd_reg, kd_next;
    logic           push, pop;

    assign adv     = !(v6_reg && kv_reg);
    assign s_ready = adv;
    assign push    = adv && v6_reg;
    assign pop     = ov_reg && m_ready;

    always_comb begin
        ov_next = ov_reg;
        od_next = od_reg;
        kv_next = kv_reg;
        kd_next = kd_reg;
        if (pop) begin
            if (kv_reg) begin
                od_next = kd_reg;
                kv_next = 1'b0;
            end else begin
                ov_next = 1'b0;
            end
        end
        if (push) begin
            if (!ov_next) begin
                ov_next = 1'b1;
                od_next = res;
            end else begin
                kv_next = 1'b1;
                kd_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            ov_reg <= 1'b0;
            kv_reg <= 1'b0;
        end else begin
            if (adv) begin
                v1_reg <= s_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= sq_valid;
            end
            ov_reg <= ov_next;
            kv_reg <= kv_next;
        end
    end

    always_ff @(posedge aclk) begin
        od_reg <= od_next;
        kd_reg <= kd_next;
        if (adv) begin
            sqx_reg    <= sqx_next;
            sqy_reg    <= sqy_next;
            sqz_reg    <= sqz_next;
            dpx_reg    <= dpx_next;
            dpy_reg    <= dpy_next;
            dpz_reg    <= dpz_next;
            r2_2_reg   <= r2_2_next;
            acc_reg    <= acc_next;
            r2_3_reg   <= r2_2_reg;
            b3_reg     <= b3_next;
            layer3_reg <= layer3_next;
            out3_reg   <= out3_next;
            r2_4_reg   <= r2_3_reg;
            bb_reg     <= bb_next;
            rsq_o_reg  <= rsq_o_next;
            rsq_1_reg  <= rsq_1_next;
            rsq_2_reg  <= rsq_2_next;
            b4_reg     <= b3_reg;
            layer4_reg <= layer3_reg;
            out4_reg   <= out3_reg;
            use1_reg   <= use1_next;
            use2_reg   <= use2_next;
            rad5_reg   <= rad5_next;
            side5_reg  <= side5_next;
            so_reg     <= so_next;
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            rad6_reg   <= sq_root[sssl_pkg::LANE_RADIUS][sssl_pkg::RADIUS_W-1:0];
            layer6_reg <= sq_side.layer;
            out6_reg   <= sq_side.outside;
            hit1_reg   <= sq_side.hit1;
            hit2_reg   <= sq_side.hit2;
        end
    end

    assign m_valid    = ov_reg;
    assign m_outside  = od_reg.outside;
    assign m_layer    = od_reg.layer;
    assign m_radius   = od_reg.radius;
    assign m_step_len = od_reg.step_len;

endmodule

// ----- rtl/sssl_checker.sv -----
// Port-level checker for the shell step locator, bound to the top level.
`include "spherical_shell_step_locator_unit_macros.svh"

module sssl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_outside,
    input logic [3:0]  m_layer,
    input logic [29:0] m_radius,
    input logic [31:0] m_step_len
);

    // a stalled result transaction holds
    `SSSL_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_outside) && $stable(m_layer) && $stable(m_radius) && $stable(m_step_len))

    // points beyond orbit carry all-zero fields
    `SSSL_ASSERT_SAME(a_outside_zero, aclk, aresetn, m_valid && m_outside, (m_layer == 4'd0) && (m_radius == 30'd0) && (m_step_len == 32'd0))

    // inside points: step clamped to one metre, layer within the table
    `SSSL_ASSERT_SAME(a_inside_step, aclk, aresetn, m_valid && !m_outside, (m_step_len >= 32'd16) && (m_layer <= 4'd14))

    // inside points lie within the orbit radius
    `SSSL_ASSERT_SAME(a_inside_radius, aclk, aresetn, m_valid && !m_outside, m_radius <= 30'd674624000)

endmodule

bind spherical_shell_step_locator_unit sssl_checker u_sssl_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_outside  (m_outside),
    .m_layer    (m_layer),
    .m_radius   (m_radius),
    .m_step_len (m_step_len)
);
